// ----- rtl/dtrt_pkg.sv -----
package dtrt_pkg;

    localparam int unsigned CNT_W   = 16;
    localparam int unsigned FPS_W   = 7;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned TOT_W   = 18;
    localparam int unsigned NUM_W   = CNT_W + 1;
    localparam int unsigned PROD_W  = CNT_W + FPS_W;
    localparam int unsigned STEP_W  = $clog2(NUM_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_RATE_REQ   = 3'd0,
        CMD_ADD_CREDIT = 3'd1,
        CMD_RATE_ALLOC = 3'd2,
        CMD_VOL_REQ    = 3'd3,
        CMD_VOL_ALLOC  = 3'd4,
        CMD_FREE_ALLOC = 3'd5,
        CMD_TICK       = 3'd6
    } t_cmd;

    typedef enum logic [IDX_W-1:0] {
        REG_GUAR_RATE = 3'd0,
        REG_MAX_RATE  = 3'd1,
        REG_TIMEOUT   = 3'd2,
        REG_MAX_VOL   = 3'd3,
        REG_FPS       = 3'd4
    } t_reg_idx;

endpackage

// ----- rtl/dama_terminal_request_tracker.sv -----
// Each item runs S_SUB (volume alloc only), S_LOAD, S_DIV and S_DONE in turn; S_DIV
// is the 17-step restoring divider that forms the rounded-up volume per frame, and
// S_DONE waits while a stalled result is held. Input stalls until S_DONE is left.
// A finished result sits in the output register while the next item is taken.
// Reset is synchronous, active low; request and allocation counters clear, frame count resets to 1.
module dama_terminal_request_tracker
    import dtrt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [CNT_W-1:0]     i_amount,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CNT_W-1:0]     o_rate_request,
    output logic [CNT_W-1:0]     o_rate_credit,
    output logic [CNT_W-1:0]     o_volume_per_frame,
    output logic [TOT_W-1:0]     o_total_rate_alloc,
    output logic [CNT_W-1:0]     o_total_volume_alloc
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    localparam logic [CNT_W-1:0]  SAT       = '1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_guar_rate, n_guar_rate;
    logic [CNT_W-1:0]  r_max_rate, n_max_rate;
    logic [CNT_W-1:0]  r_timeout, n_timeout;
    logic [CNT_W-1:0]  r_max_vol, n_max_vol;
    logic [FPS_W-1:0]  r_fps, n_fps;

    logic [CNT_W-1:0]  r_rate_req, n_rate_req;
    logic [CNT_W-1:0]  r_credit, n_credit;
    logic [CNT_W-1:0]  r_timeout_left, n_timeout_left;
    logic [CNT_W-1:0]  r_rate_alloc, n_rate_alloc;
    logic [CNT_W-1:0]  r_volume_req, n_volume_req;
    logic [CNT_W-1:0]  r_volume_alloc, n_volume_alloc;
    logic [CNT_W-1:0]  r_free_alloc, n_free_alloc;

    logic [PROD_W-1:0] r_prod, n_prod;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [FPS_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0] r_step, n_step;

    logic              r_out_valid, n_out_valid;
    logic [CNT_W-1:0]  r_o_rate_req, n_o_rate_req;
    logic [CNT_W-1:0]  r_o_credit, n_o_credit;
    logic [CNT_W-1:0]  r_o_vpf, n_o_vpf;
    logic [TOT_W-1:0]  r_o_trate, n_o_trate;
    logic [CNT_W-1:0]  r_o_tvol, n_o_tvol;

    logic              w_accept;
    logic [FPS_W-1:0]  w_fc;
    logic [NUM_W-1:0]  w_cred_sum;
    logic [NUM_W-1:0]  w_vol_sum;
    logic [NUM_W-1:0]  w_valloc_sum;
    logic [CNT_W-1:0]  w_tl_dec;
    logic [FPS_W:0]    w_rem_sh;
    logic              w_ge;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_fc         = (r_fps == '0) ? FPS_W'(1) : r_fps;
    assign w_cred_sum   = {1'b0, r_credit} + {1'b0, i_amount};
    assign w_vol_sum    = {1'b0, r_volume_req} + {1'b0, i_amount};
    assign w_valloc_sum = {1'b0, r_volume_alloc} + {1'b0, i_amount};
    assign w_tl_dec     = (r_timeout_left != '0) ? r_timeout_left - CNT_W'(1) : '0;

    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, w_fc});

    always_comb begin
        n_state        = r_state;
        n_guar_rate    = r_guar_rate;
        n_max_rate     = r_max_rate;
        n_timeout      = r_timeout;
        n_max_vol      = r_max_vol;
        n_fps          = r_fps;
        n_rate_req     = r_rate_req;
        n_credit       = r_credit;
        n_timeout_left = r_timeout_left;
        n_rate_alloc   = r_rate_alloc;
        n_volume_req   = r_volume_req;
        n_volume_alloc = r_volume_alloc;
        n_free_alloc   = r_free_alloc;
        n_prod         = r_prod;
        n_num          = r_num;
        n_rem          = r_rem;
        n_step         = r_step;
        n_out_valid    = r_out_valid && i_out_stall;
        n_o_rate_req   = r_o_rate_req;
        n_o_credit     = r_o_credit;
        n_o_vpf        = r_o_vpf;
        n_o_trate      = r_o_trate;
        n_o_tvol       = r_o_tvol;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GUAR_RATE: n_guar_rate = i_cfg_data;
                REG_MAX_RATE:  n_max_rate  = i_cfg_data;
                REG_TIMEOUT:   n_timeout   = i_cfg_data;
                REG_MAX_VOL:   n_max_vol   = i_cfg_data;
                REG_FPS:       n_fps       = i_cfg_data[FPS_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_LOAD;
                    unique case (i_cmd)
                        CMD_RATE_REQ: begin
                            n_rate_req     = (i_amount < r_max_rate) ? i_amount : r_max_rate;
                            n_credit       = '0;
                            n_timeout_left = r_timeout;
                        end
                        CMD_ADD_CREDIT: begin
                            n_credit = w_cred_sum[CNT_W] ? SAT : w_cred_sum[CNT_W-1:0];
                        end
                        CMD_RATE_ALLOC: n_rate_alloc = i_amount;
                        CMD_VOL_REQ: begin
                            n_volume_req = (w_vol_sum < {1'b0, r_max_vol}) ?
                                           w_vol_sum[CNT_W-1:0] : r_max_vol;
                        end
                        CMD_VOL_ALLOC: begin
                            n_volume_alloc = w_valloc_sum[CNT_W] ? SAT :
                                             w_valloc_sum[CNT_W-1:0];
                            n_prod  = {{FPS_W{1'b0}}, i_amount} * {{CNT_W{1'b0}}, w_fc};
                            n_state = S_SUB;
                        end
                        CMD_FREE_ALLOC: n_free_alloc = i_amount;
                        CMD_TICK: begin
                            n_timeout_left = w_tl_dec;
                            if (w_tl_dec != '0) begin
                                if (r_credit != '0) begin
                                    n_credit   = r_credit - CNT_W'(1);
                                    n_rate_req = (r_rate_req == SAT) ? SAT :
                                                 r_rate_req + CNT_W'(1);
                                end
                            end else begin
                                n_rate_req = '0;
                                n_credit   = '0;
                            end
                            n_rate_alloc   = '0;
                            n_volume_alloc = '0;
                            n_free_alloc   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SUB: begin
                n_volume_req = ({{FPS_W{1'b0}}, r_volume_req} >= r_prod) ?
                               r_volume_req - r_prod[CNT_W-1:0] : '0;
                n_state      = S_LOAD;
            end
            S_LOAD: begin
                n_num   = {1'b0, r_volume_req} + {{(NUM_W-FPS_W){1'b0}}, w_fc} - NUM_W'(1);
                n_rem   = '0;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = w_ge ? FPS_W'(w_rem_sh - {1'b0, w_fc}) : w_rem_sh[FPS_W-1:0];
                n_num  = {r_num[NUM_W-2:0], w_ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_o_rate_req = r_rate_req;
                    n_o_credit   = r_credit;
                    n_o_vpf      = r_num[CNT_W-1:0];
                    n_o_trate    = {2'b00, r_rate_alloc} + {2'b00, r_free_alloc} +
                                   {2'b00, r_guar_rate};
                    n_o_tvol     = r_volume_alloc;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod       <= n_prod;
        r_num        <= n_num;
        r_rem        <= n_rem;
        r_step       <= n_step;
        r_o_rate_req <= n_o_rate_req;
        r_o_credit   <= n_o_credit;
        r_o_vpf      <= n_o_vpf;
        r_o_trate    <= n_o_trate;
        r_o_tvol     <= n_o_tvol;
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_guar_rate    <= '0;
            r_max_rate     <= '0;
            r_timeout      <= '0;
            r_max_vol      <= '0;
            r_fps          <= FPS_W'(1);
            r_rate_req     <= '0;
            r_credit       <= '0;
            r_timeout_left <= '0;
            r_rate_alloc   <= '0;
            r_volume_req   <= '0;
            r_volume_alloc <= '0;
            r_free_alloc   <= '0;
        end else begin
            r_state        <= n_state;
            r_out_valid    <= n_out_valid;
            r_guar_rate    <= n_guar_rate;
            r_max_rate     <= n_max_rate;
            r_timeout      <= n_timeout;
            r_max_vol      <= n_max_vol;
            r_fps          <= n_fps;
            r_rate_req     <= n_rate_req;
            r_credit       <= n_credit;
            r_timeout_left <= n_timeout_left;
            r_rate_alloc   <= n_rate_alloc;
            r_volume_req   <= n_volume_req;
            r_volume_alloc <= n_volume_alloc;
            r_free_alloc   <= n_free_alloc;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_rate_request       = r_o_rate_req;
    assign o_rate_credit        = r_o_credit;
    assign o_volume_per_frame   = r_o_vpf;
    assign o_total_rate_alloc   = r_o_trate;
    assign o_total_volume_alloc = r_o_tvol;

endmodule

// ----- rtl/dtrt_checker.sv -----
module dtrt_checker
    import dtrt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [CNT_W-1:0]     i_amount,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  logic [CNT_W-1:0]     o_rate_request,
    input  logic [CNT_W-1:0]     o_rate_credit,
    input  logic [CNT_W-1:0]     o_volume_per_frame,
    input  logic [TOT_W-1:0]     o_total_rate_alloc,
    input  logic [CNT_W-1:0]     o_total_volume_alloc
);

    logic w_in_xfer;

    assign w_in_xfer = i_in_valid && !o_in_stall;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not idle after reset");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_in_stall)
        else $error("input taken again right after a transfer");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("result appeared too early after a transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rate_request)
            && $stable(o_rate_credit) && $stable(o_volume_per_frame)
            && $stable(o_total_rate_alloc) && $stable(o_total_volume_alloc))
        else $error("stalled result changed");

endmodule

bind dama_terminal_request_tracker dtrt_checker u_dtrt_checker (.*);
